// ----- hw/rtl/hzdec_pkg.sv -----
// Package with mode, command and status codes and character constants for the HZ decoder.
`default_nettype none

package hzdec_pkg;

	typedef enum logic [2:0] {
		MODE_ASCII   = 3'd0,
		MODE_TILDE   = 3'd1,
		MODE_GB      = 3'd2,
		MODE_LEAD    = 3'd3,
		MODE_GBTILDE = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_END   = 2'd1,
		CMD_RESET = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ILLEGAL    = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	localparam logic [7:0] HIGH_BIT = 8'h80;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/hz_to_euc_gb_decoder.sv -----
// HZ to EUC-GB2312 byte stream decoder, top level.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per cycle
//   unless stalled: a command and an HZ byte. Command data decodes the byte,
//   command end asks whether the stream may stop here, command reset forces
//   ASCII mode. Every request gives exactly one result on the output channel
//   (out_valid/out_ready): up to two EUC bytes with their count, and a
//   status of ok, illegal sequence or incomplete input.
//   The result is registered: the decode mode and held lead byte are updated
//   at the accepting edge and the result lands in the output register.
//   Throughput is one request per cycle, set by the mode update
//   loop; in_ready stays high while the output register is empty or being
//   drained in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken.
//   After reset the mode is ASCII and the output register is empty. The held
//   lead byte has no reset; it is read only after a write.
`default_nettype none

module hz_to_euc_gb_decoder
	import hzdec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_count,
	output logic [7:0]      out_first,
	output logic [7:0]      out_second,
	output logic [1:0]      status
);

	mode_t       mode_q;
	mode_t       mode_d;
	logic [7:0]  held_q;
	logic        held_we;
	logic        out_valid_q;
	logic [1:0]  count_d, count_q;
	logic [7:0]  first_d, first_q;
	logic [7:0]  second_d, second_q;
	status_t     status_d, status_q;
	logic        accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// next state
	always_comb begin
		mode_d  = mode_q;
		held_we = 1'b0;
		case (cmd_t'(command))
			CMD_RESET: begin
				mode_d = MODE_ASCII;
			end
			CMD_DATA: begin
				case (mode_q)
					MODE_TILDE: begin
						if (in_byte == CH_OPEN) begin
							mode_d = MODE_GB;
						end else if (in_byte == CH_TILDE) begin
							mode_d = MODE_ASCII;
						end
					end
					MODE_GB: begin
						if (in_byte == CH_TILDE) begin
							mode_d = MODE_GBTILDE;
						end else begin
							mode_d  = MODE_LEAD;
							held_we = 1'b1;
						end
					end
					MODE_LEAD: begin
						mode_d = MODE_GB;
					end
					MODE_GBTILDE: begin
						if (in_byte == CH_CLOSE) begin
							mode_d = MODE_ASCII;
						end
					end
					default: begin
						if (in_byte == CH_TILDE) begin
							mode_d = MODE_TILDE;
						end else if ((in_byte & HIGH_BIT) == 8'h00) begin
							mode_d = MODE_ASCII;
						end
					end
				endcase
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	// outputs
	always_comb begin
		count_d  = CNT_NONE;
		first_d  = 8'h00;
		second_d = 8'h00;
		status_d = ST_OK;
		case (cmd_t'(command))
			CMD_END: begin
				if (mode_q != MODE_ASCII) begin
					status_d = ST_INCOMPLETE;
				end
			end
			CMD_DATA: begin
				case (mode_q)
					MODE_TILDE: begin
						if (in_byte == CH_TILDE) begin
							count_d = CNT_ONE;
							first_d = CH_TILDE;
						end else if (in_byte != CH_OPEN) begin
							status_d = ST_ILLEGAL;
						end
					end
					MODE_GB: begin
						status_d = ST_OK;
					end
					MODE_LEAD: begin
						count_d  = CNT_TWO;
						first_d  = held_q | HIGH_BIT;
						second_d = in_byte | HIGH_BIT;
					end
					MODE_GBTILDE: begin
						if (in_byte != CH_CLOSE) begin
							status_d = ST_ILLEGAL;
						end
					end
					default: begin
						if (in_byte != CH_TILDE) begin
							if ((in_byte & HIGH_BIT) == 8'h00) begin
								count_d = CNT_ONE;
								first_d = in_byte;
							end else begin
								status_d = ST_ILLEGAL;
							end
						end
					end
				endcase
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ASCII;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q <= in_byte;
		end
		if (accept) begin
			count_q  <= count_d;
			first_q  <= first_d;
			second_q <= second_d;
			status_q <= status_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_count  = count_q;
	assign out_first  = first_q;
	assign out_second = second_q;
	assign status     = status_q;

	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_RESET |=> mode_q == MODE_ASCII)
		else $error("reset request did not return to ascii mode");

	a_pair_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_DATA && mode_q == MODE_LEAD |=>
		out_valid && count_q == CNT_TWO && first_q[7] && second_q[7])
		else $error("trail byte did not release a byte pair");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q != ST_OK |-> count_q == CNT_NONE)
		else $error("error result carries output bytes");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d == ST_ILLEGAL |=> $stable(mode_q))
		else $error("illegal sequence changed the mode");

	a_end_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_END && mode_q == MODE_ASCII |=> status_q == ST_OK)
		else $error("end request flagged in ascii mode");

endmodule

`default_nettype wire
